### design/overlapped_frame_rms_energy_defines.svh
// Assertion macros shared by the RTL of the frame RMS block.
`ifndef OVERLAPPED_FRAME_RMS_ENERGY_DEFINES_SVH
`define OVERLAPPED_FRAME_RMS_ENERGY_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OFRE_ASSERT_IMP(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define OFRE_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### design/ofre_pkg.sv
package ofre_pkg;

  localparam int MAX_HOP     = 4096;
  localparam int SAMPLE_BITS = 16;

  // Accumulator widths follow from the sample width and the longest hop.
  localparam int HOP_W     = $clog2(MAX_HOP) + 1;
  localparam int CNT_W     = HOP_W;
  localparam int SQ_W      = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W     = SQ_W - 1 + HOP_W;
  localparam int WIN_SUM_W = SUM_W + 1;
  localparam int WIN_CNT_W = CNT_W + 1;

  // Iterative divide and square root.
  localparam int ROOT_W    = (WIN_SUM_W + 1) / 2;
  localparam int DIV_STEPS = WIN_SUM_W;
  localparam int DP_W      = WIN_SUM_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [WIN_SUM_W-1:0] ROOT_INIT = WIN_SUM_W'(1) << (2 * ROOT_W - 2);

  // Port field widths.
  localparam int HOP_CFG_W   = 13;
  localparam int NF_W        = 21;
  localparam int CFG_DATA_W  = 21;
  localparam int CFG_IDX_W   = 1;
  localparam int FRAME_CNT_W = 21;
  localparam int INDEX_W     = 20;
  localparam int RMS_W       = 16;
  localparam int COUNTED_W   = 14;

  localparam logic [CFG_IDX_W-1:0] REG_HOP_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES = CFG_IDX_W'(1);

  localparam logic [HOP_CFG_W-1:0]   HOP_RESET     = HOP_CFG_W'(160);
  localparam logic [NF_W-1:0]        NF_RESET      = NF_W'(1048576);
  localparam logic [FRAME_CNT_W-1:0] FRAME_CNT_MAX = '1;
  localparam logic [FRAME_CNT_W-1:0] FRAME_IDX_MAX = FRAME_CNT_W'(1048575);

  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_ROOT,
    C_DONE
  } calc_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SQUARE,
    T_ACCUM,
    T_DECIDE,
    T_START,
    T_WAIT,
    T_PUT
  } top_state_t;

  typedef struct packed {
    logic                 start;
    logic [WIN_SUM_W-1:0] sum;
    logic [WIN_CNT_W-1:0] cnt;
  } calc_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } calc_rsp_t;

endpackage

### design/ofre_sample_if.sv
interface ofre_sample_if;
  import ofre_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

### design/ofre_frame_if.sv
interface ofre_frame_if;
  import ofre_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RMS_W-1:0]     rms;
  logic [INDEX_W-1:0]   frame_index;
  logic [COUNTED_W-1:0] samples_counted;
  logic                 final_frame;

  modport source (output valid, output rms, output frame_index, output samples_counted,
                  output final_frame, input ready);
  modport sink (input valid, input rms, input frame_index, input samples_counted,
                input final_frame, output ready);
endinterface

### design/ofre_calc.sv
module ofre_calc (
  input  logic                clk,
  input  logic                rst,
  input  ofre_pkg::calc_req_t req,
  output ofre_pkg::calc_rsp_t rsp
);
  import ofre_pkg::*;

  calc_state_t          state;
  calc_state_t          state_next;
  logic [DP_W-1:0]      acc;
  logic [WIN_SUM_W-1:0] work;
  logic [WIN_SUM_W-1:0] bitm;
  logic [WIN_CNT_W-1:0] den;
  logic [STEP_W-1:0]    step;

  logic [DP_W-1:0]      rem_sh;
  logic [DP_W-1:0]      sub_a;
  logic [DP_W-1:0]      sub_b;
  logic [DP_W:0]        sub_full;
  logic [DP_W-1:0]      diff;
  logic                 ge;
  logic [WIN_SUM_W-1:0] quo_next;
  logic                 div_last;
  logic                 root_last;

  // One subtractor serves both the restoring divide and the square root.
  always_comb begin
    rem_sh = {acc[DP_W-2:0], work[WIN_SUM_W-1]};
    if (state == C_DIV) begin
      sub_a = rem_sh;
      sub_b = {{(DP_W - WIN_CNT_W){1'b0}}, den};
    end else begin
      sub_a = acc;
      sub_b = {1'b0, work | bitm};
    end
    sub_full  = {1'b0, sub_a} - {1'b0, sub_b};
    ge        = !sub_full[DP_W];
    diff      = sub_full[DP_W-1:0];
    quo_next  = {work[WIN_SUM_W-2:0], ge};
    div_last  = (step == STEP_W'(DIV_STEPS - 1));
    root_last = (step == STEP_W'(ROOT_W - 1));
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (req.start) begin
          state_next = (req.cnt == '0) ? C_DONE : C_DIV;
        end
      end
      C_DIV: begin
        if (div_last) begin
          state_next = C_ROOT;
        end
      end
      C_ROOT: begin
        if (root_last) begin
          state_next = C_DONE;
        end
      end
      C_DONE:  state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    rsp.busy = (state != C_IDLE);
    rsp.done = (state == C_DONE);
    rsp.root = work[ROOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (req.start) begin
          acc  <= '0;
          work <= (req.cnt == '0) ? '0 : req.sum;
          den  <= req.cnt;
          step <= '0;
        end
      end
      C_DIV: begin
        if (div_last) begin
          // The quotient becomes the radicand for the root phase.
          acc  <= {1'b0, quo_next};
          work <= '0;
          bitm <= ROOT_INIT;
          step <= '0;
        end else begin
          acc  <= ge ? diff : rem_sh;
          work <= quo_next;
          step <= step + 1'b1;
        end
      end
      C_ROOT: begin
        if (ge) begin
          acc  <= diff;
          work <= (work >> 1) | bitm;
        end else begin
          work <= work >> 1;
        end
        bitm <= bitm >> 2;
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/overlapped_frame_rms_energy.sv
// Overlapped frame RMS energy.
// Samples enter on the samples channel (signed Q1.15 plus a last flag); one
// RMS value per frame leaves on the frames channel, together with its frame
// index, the number of samples in its two-hop window and a final-frame flag.
// Registers hop_size (index 0) and num_frames (index 1) are written through
// cfg_we/cfg_index/cfg_data; the user is to write them while the block is idle,
// which the block itself does not enforce. A sample that completes no frame
// passes through the square, accumulate and decide states before the next
// sample is taken. For a sample that completes a hop block, the single shared
// subtractor runs a 44-step restoring divide and a 22-step square root for
// each frame. The last sample flushes up to two frames. Frame results appear
// one at a time in an output register; the block keeps taking samples while a
// result waits there, and it holds off only when a new result is ready and the
// receiver has not yet taken the previous one.
// Synchronous reset clears the accumulators and frame counter and restores
// hop_size to 160 and num_frames to 1048576.
`include "overlapped_frame_rms_energy_defines.svh"

module overlapped_frame_rms_energy (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ofre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ofre_pkg::CFG_DATA_W-1:0]  cfg_data,
  ofre_sample_if.sink                      samples,
  ofre_frame_if.source                     frames
);
  import ofre_pkg::*;

  typedef struct packed {
    logic                   en;
    logic [FRAME_CNT_W-1:0] index;
    logic [WIN_SUM_W-1:0]   sum;
    logic [WIN_CNT_W-1:0]   cnt;
    logic                   fin;
  } frame_job_t;

  top_state_t             state;
  top_state_t             state_next;
  logic [HOP_CFG_W-1:0]   hop_size;
  logic [NF_W-1:0]        num_frames;
  logic [SUM_W-1:0]       block_sum;
  logic [CNT_W-1:0]       block_count;
  logic [SUM_W-1:0]       prior_sum;
  logic [CNT_W-1:0]       prior_count;
  logic [FRAME_CNT_W-1:0] frame_counter;
  logic                   out_valid;

  logic [SAMPLE_BITS-1:0] smp;
  logic                   smp_last;
  logic [SQ_W-1:0]        sq;
  frame_job_t             job0;
  frame_job_t             job1;
  logic                   sel;
  logic [ROOT_W-1:0]      root;
  logic [RMS_W-1:0]       out_rms;
  logic [INDEX_W-1:0]     out_index;
  logic [COUNTED_W-1:0]   out_counted;
  logic                   out_final;

  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] prod;
  logic [CNT_W-1:0]         hop_eff;
  logic                     block_done;
  logic [WIN_SUM_W-1:0]     win_sum;
  logic [WIN_CNT_W-1:0]     win_cnt;
  logic [FRAME_CNT_W-1:0]   k1;
  logic                     allow0;
  logic                     allow1;
  frame_job_t               dec0;
  frame_job_t               dec1;
  frame_job_t               cur;
  logic                     slot_free;
  calc_req_t                calc_req;
  calc_rsp_t                calc_rsp;

  ofre_calc u_calc (
    .clk (clk),
    .rst (rst),
    .req (calc_req),
    .rsp (calc_rsp)
  );

  always_comb begin
    mag  = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
    prod = mag * mag;

    if (hop_size == '0) begin
      hop_eff = CNT_W'(1);
    end else if (32'(hop_size) > 32'(MAX_HOP)) begin
      hop_eff = CNT_W'(MAX_HOP);
    end else begin
      hop_eff = CNT_W'(hop_size);
    end
    block_done = (block_count >= hop_eff);

    win_sum = {1'b0, prior_sum} + {1'b0, block_sum};
    win_cnt = {1'b0, prior_count} + {1'b0, block_count};
    k1      = (frame_counter != FRAME_CNT_MAX) ? frame_counter + 1'b1 : frame_counter;
    allow0  = (frame_counter < num_frames) && (frame_counter <= FRAME_IDX_MAX);
    allow1  = (k1 != frame_counter) && (k1 < num_frames) && (k1 <= FRAME_IDX_MAX);

    dec0 = '0;
    dec1 = '0;
    if (smp_last) begin
      // The final sample flushes the current frame and the one after it.
      dec0 = '{en: allow0, index: frame_counter, sum: win_sum, cnt: win_cnt, fin: !allow1};
      dec1 = '{en: allow1, index: k1, sum: {1'b0, block_sum},
               cnt: {1'b0, block_count}, fin: 1'b1};
    end else if (block_done) begin
      dec0 = '{en: allow0, index: frame_counter, sum: win_sum, cnt: win_cnt, fin: 1'b0};
    end

    cur       = sel ? job1 : job0;
    slot_free = !out_valid || frames.ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (samples.valid) begin
          state_next = T_SQUARE;
        end
      end
      T_SQUARE: state_next = T_ACCUM;
      T_ACCUM:  state_next = T_DECIDE;
      T_DECIDE: state_next = (dec0.en || dec1.en) ? T_START : T_IDLE;
      T_START:  state_next = T_WAIT;
      T_WAIT: begin
        if (calc_rsp.done) begin
          state_next = T_PUT;
        end
      end
      T_PUT: begin
        if (slot_free) begin
          state_next = (!sel && job1.en) ? T_START : T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    samples.ready  = (state == T_IDLE);
    calc_req.start = (state == T_START);
    calc_req.sum   = cur.sum;
    calc_req.cnt   = cur.cnt;
  end

  assign frames.valid           = out_valid;
  assign frames.rms             = out_rms;
  assign frames.frame_index     = out_index;
  assign frames.samples_counted = out_counted;
  assign frames.final_frame     = out_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      hop_size      <= HOP_RESET;
      num_frames    <= NF_RESET;
      block_sum     <= '0;
      block_count   <= '0;
      prior_sum     <= '0;
      prior_count   <= '0;
      frame_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_HOP_SIZE:   hop_size   <= cfg_data[HOP_CFG_W-1:0];
          REG_NUM_FRAMES: num_frames <= cfg_data[NF_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == T_ACCUM) begin
        block_sum   <= block_sum + SUM_W'(sq);
        block_count <= block_count + 1'b1;
      end

      if (state == T_DECIDE) begin
        if (smp_last) begin
          block_sum     <= '0;
          block_count   <= '0;
          prior_sum     <= '0;
          prior_count   <= '0;
          frame_counter <= '0;
        end else if (block_done) begin
          prior_sum     <= block_sum;
          prior_count   <= block_count;
          block_sum     <= '0;
          block_count   <= '0;
          frame_counter <= k1;
        end
      end

      if (state == T_PUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (frames.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      smp      <= samples.sample;
      smp_last <= samples.last;
    end
    if (state == T_SQUARE) begin
      sq <= prod[SQ_W-1:0];
    end
    if (state == T_DECIDE) begin
      job0 <= dec0;
      job1 <= dec1;
      sel  <= !dec0.en;
    end
    if (state == T_WAIT && calc_rsp.done) begin
      root <= calc_rsp.root;
    end
    if (state == T_PUT && slot_free) begin
      out_rms     <= root[RMS_W-1:0];
      out_index   <= cur.index[INDEX_W-1:0];
      out_counted <= COUNTED_W'(cur.cnt);
      out_final   <= cur.fin;
      if (!sel && job1.en) begin
        sel <= 1'b1;
      end
    end
  end

  `OFRE_ASSERT_NEXT(a_hold_after_accept, clk, rst, samples.valid && samples.ready, !samples.ready)
  `OFRE_ASSERT_IMP(a_block_bound, clk, rst, 1'b1, 32'(block_count) <= 32'(MAX_HOP))
  `OFRE_ASSERT_IMP(a_calc_idle_on_start, clk, rst, calc_req.start, !calc_rsp.busy)
  `OFRE_ASSERT_IMP(a_load_from_put, clk, rst, $rose(frames.valid), $past(state) == T_PUT)

endmodule
